FILE: hw/rtl/wmr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wmr_pkg
// Shared widths, sequencer states and control types for the 128-by-64-bit
// modulo reduction block.
// ============================================================================
package wmr_pkg;

    localparam int DataWidth     = 64;
    localparam int DividendWidth = 2 * DataWidth;
    localparam int CountWidth    = $clog2(DividendWidth);

    localparam logic [CountWidth-1:0] LastCount = CountWidth'(DividendWidth - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } wmr_state_t;

    // Control from the sequencer to the reduction unit.
    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } wmr_ctrl_t;

endpackage

FILE: hw/rtl/wmr_if.sv
`timescale 1ns / 1ps
// ============================================================================
// wmr_in_if / wmr_out_if
// Valid/ready channels for the modulo reduction requests and results.
// ============================================================================
interface wmr_in_if;
    logic                            valid;
    logic                            ready;
    logic [wmr_pkg::DataWidth-1:0]   dividend_high;
    logic [wmr_pkg::DataWidth-1:0]   dividend_low;
    logic [wmr_pkg::DataWidth-1:0]   modulus;

    modport source (output valid, output dividend_high, output dividend_low,
                    output modulus, input ready);
    modport sink   (input valid, input dividend_high, input dividend_low,
                    input modulus, output ready);
endinterface

interface wmr_out_if;
    logic                            valid;
    logic                            ready;
    logic [wmr_pkg::DataWidth-1:0]   remainder;
    logic                            divide_error;

    modport source (output valid, output remainder, output divide_error,
                    input ready);
    modport sink   (input valid, input remainder, input divide_error,
                    output ready);
endinterface

FILE: hw/rtl/wmr_reduce_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// wmr_reduce_unit
// Restoring reduction datapath: one shift-and-conditional-subtract per step,
// plus the result register.
// ============================================================================
module wmr_reduce_unit (
    input  logic                          clk,
    input  wmr_pkg::wmr_ctrl_t            ctrl,
    input  logic [wmr_pkg::DataWidth-1:0] dividend_high,
    input  logic [wmr_pkg::DataWidth-1:0] dividend_low,
    input  logic [wmr_pkg::DataWidth-1:0] modulus,
    output logic [wmr_pkg::DataWidth-1:0] remainder,
    output logic                          divide_error
);

    logic [wmr_pkg::DividendWidth-1:0] dividend_reg, dividend_next;
    logic [wmr_pkg::DataWidth-1:0]     modulus_reg, modulus_next;
    logic [wmr_pkg::DataWidth-1:0]     rem_reg, rem_next;
    logic                              zero_mod_reg, zero_mod_next;
    logic [wmr_pkg::DataWidth-1:0]     remainder_reg, remainder_next;
    logic                              error_reg, error_next;

    logic [wmr_pkg::DataWidth:0]       shifted;
    logic [wmr_pkg::DataWidth:0]       diff;

    // The bit shifted out of the running remainder is kept as a 65th bit, so
    // the compare against the modulus is a single wide subtract.
    assign shifted = {rem_reg, dividend_reg[wmr_pkg::DividendWidth-1]};
    assign diff    = shifted - {1'b0, modulus_reg};

    always_comb
    begin
        dividend_next  = dividend_reg;
        modulus_next   = modulus_reg;
        rem_next       = rem_reg;
        zero_mod_next  = zero_mod_reg;
        remainder_next = remainder_reg;
        error_next     = error_reg;
        if (ctrl.load)
        begin
            dividend_next = {dividend_high, dividend_low};
            modulus_next  = modulus;
            rem_next      = '0;
            zero_mod_next = (modulus == '0);
        end
        if (ctrl.step)
        begin
            dividend_next = {dividend_reg[wmr_pkg::DividendWidth-2:0], 1'b0};
            if (!diff[wmr_pkg::DataWidth])
            begin
                rem_next = diff[wmr_pkg::DataWidth-1:0];
            end
            else
            begin
                rem_next = shifted[wmr_pkg::DataWidth-1:0];
            end
        end
        if (ctrl.publish)
        begin
            remainder_next = zero_mod_reg ? '0 : rem_reg;
            error_next     = zero_mod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg  <= dividend_next;
        modulus_reg   <= modulus_next;
        rem_reg       <= rem_next;
        zero_mod_reg  <= zero_mod_next;
        remainder_reg <= remainder_next;
        error_reg     <= error_next;
    end

    assign remainder    = remainder_reg;
    assign divide_error = error_reg;

endmodule

FILE: hw/rtl/wmr_sequencer.sv
`timescale 1ns / 1ps
// ============================================================================
// wmr_sequencer
// Steps the reduction unit through the 128 dividend bits and manages the
// request and result handshakes.
// ============================================================================
module wmr_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output wmr_pkg::wmr_ctrl_t ctrl
);

    wmr_pkg::wmr_state_t               state_reg, state_next;
    logic [wmr_pkg::CountWidth-1:0]    count_reg, count_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wmr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wmr_pkg::S_RUN;
                end
            end
            wmr_pkg::S_RUN:
            begin
                if (count_reg == '0)
                begin
                    state_next = wmr_pkg::S_DONE;
                end
            end
            wmr_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = wmr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wmr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.step    = 1'b0;
        ctrl.publish = 1'b0;
        case (state_reg)
            wmr_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            wmr_pkg::S_RUN:
            begin
                ctrl.step = 1'b1;
            end
            wmr_pkg::S_DONE:
            begin
                ctrl.publish = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.load)
        begin
            count_next = wmr_pkg::LastCount;
        end
        else if (ctrl.step)
        begin
            count_next = count_reg - 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (ctrl.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wmr_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.load && ctrl.step))
        else $error("load and step issued together");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> (state_reg == wmr_pkg::S_RUN && count_reg == wmr_pkg::LastCount))
        else $error("accepted request did not start a full pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wmr_pkg::S_RUN && count_reg == '0) |=> state_reg == wmr_pkg::S_DONE)
        else $error("pass did not finish after the last bit");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.publish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

endmodule

FILE: hw/rtl/wide_modulo_reduce_top.sv
`timescale 1ns / 1ps
// ============================================================================
// wide_modulo_reduce_top
// Unsigned 128-bit by 64-bit modulo reduction with valid/ready channels.
// ============================================================================
// Each request is loaded on acceptance; then, for each of the 128 dividend bits
// in turn, a single 65-bit subtractor shifts in that bit and conditionally
// subtracts the modulus; finally the remainder moves into the output register.
// The block accepts one request at a time; a finished result may wait in the
// output register while the next request is accepted and processed. A zero
// modulus yields remainder 0 with divide_error set.
module wide_modulo_reduce_top (
    input  logic             clk,
    input  logic             rst_n,
    wmr_in_if.sink           in_ch,
    wmr_out_if.source        out_ch
);

    wmr_pkg::wmr_ctrl_t ctrl;

    wmr_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctrl      (ctrl)
    );

    wmr_reduce_unit u_unit (
        .clk           (clk),
        .ctrl          (ctrl),
        .dividend_high (in_ch.dividend_high),
        .dividend_low  (in_ch.dividend_low),
        .modulus       (in_ch.modulus),
        .remainder     (out_ch.remainder),
        .divide_error  (out_ch.divide_error)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for wide_modulo_reduce_top. Requests go in on the input
// channel, a local predictor computes the 128-by-64-bit remainder of each one,
// and every result is compared in order with its prediction. The run covers
// directed corner values, three idle mixes of random traffic, a long result
// stall and a pause in which the sender waits until the block is empty.
// ============================================================================
module testbench;

    localparam int DataWidth      = wmr_pkg::DataWidth;
    localparam int DividendWidth  = wmr_pkg::DividendWidth;

    localparam int HalfPeriod     = 6;
    localparam int ResetCycles    = 10;
    localparam int StallLimit     = 4000;
    localparam int SettleCycles   = 140;
    localparam int RandomPerPhase = 425;
    localparam int HoldOffCycles  = 600;
    localparam int PrintLimit     = 20;

    localparam logic [DataWidth-1:0] AllOnes = '1;
    localparam logic [DataWidth-1:0] TopBit  = {1'b1, {(DataWidth-1){1'b0}}};

    typedef struct packed {
        logic [DataWidth-1:0] remainder;
        logic                 divide_error;
    } residue_t;

    logic clk;
    logic rst_n;

    wmr_in_if  in_ch ();
    wmr_out_if out_ch ();

    wide_modulo_reduce_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    residue_t expected_residues[$];
    residue_t seen_residue;
    residue_t want_residue;

    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_cycles;
    int error_count;
    int requests_sent;
    int results_checked;
    int zero_modulus_count;

    initial
    begin
        clk = 1'b0;
        forever #HalfPeriod clk = ~clk;
    end

    function automatic residue_t predict_residue(logic [DataWidth-1:0] high,
                                                 logic [DataWidth-1:0] low,
                                                 logic [DataWidth-1:0] modulus);
        residue_t                 r;
        logic [DividendWidth-1:0] dividend;
        dividend = {high, low};
        if (modulus == '0)
        begin
            r.remainder    = '0;
            r.divide_error = 1'b1;
        end
        else
        begin
            r.remainder    = DataWidth'(dividend % DividendWidth'(modulus));
            r.divide_error = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [DataWidth-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(string what, logic [DataWidth-1:0] got,
                                   logic [DataWidth-1:0] want);
        error_count++;
        if (error_count <= PrintLimit)
            $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Predictions are pushed when a request is accepted and popped when a
    // result is accepted; both happen in this one process, so order is fixed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_residues.push_back(predict_residue(in_ch.dividend_high,
                                                            in_ch.dividend_low,
                                                            in_ch.modulus));
                requests_sent++;
                if (in_ch.modulus == '0)
                    zero_modulus_count++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                seen_residue.remainder    = out_ch.remainder;
                seen_residue.divide_error = out_ch.divide_error;
                if (expected_residues.size() == 0)
                begin
                    report_mismatch("result with no request outstanding",
                                    seen_residue.remainder, '0);
                end
                else
                begin
                    want_residue = expected_residues.pop_front();
                    results_checked++;
                    if (seen_residue.remainder !== want_residue.remainder)
                        report_mismatch("remainder", seen_residue.remainder,
                                        want_residue.remainder);
                    if (seen_residue.divide_error !== want_residue.divide_error)
                        report_mismatch("divide_error",
                                        DataWidth'(seen_residue.divide_error),
                                        DataWidth'(want_residue.divide_error));
                end
            end
        end
    end

    // Result side: random ready, or a long hold-off when one is requested.
    initial
    begin : result_receiver
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < StallLimit)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: nothing moved for %0d cycles, %0d results outstanding.",
                 StallLimit, expected_residues.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Valid stays high from one request to the next unless an idle gap is
    // drawn, so it is never lowered and raised within one time step.
    task automatic send_request(logic [DataWidth-1:0] high, logic [DataWidth-1:0] low,
                                logic [DataWidth-1:0] modulus);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.dividend_high <= high;
        in_ch.dividend_low  <= low;
        in_ch.modulus       <= modulus;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_residues.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_request();
        logic [DataWidth-1:0] high;
        logic [DataWidth-1:0] low;
        logic [DataWidth-1:0] modulus;
        int                   pick;
        pick = $urandom_range(99);
        if (pick < 4)
            modulus = '0;
        else if (pick < 14)
            modulus = DataWidth'($urandom_range(1, 255));
        else if (pick < 32)
            modulus = random_word() | TopBit;
        else if (pick < 62)
            modulus = random_word() >> $urandom_range(DataWidth - 1);
        else
            modulus = random_word();
        if (pick >= 4 && modulus == '0)
            modulus = DataWidth'(1);
        low = ($urandom_range(19) == 0) ? AllOnes : random_word();
        pick = $urandom_range(99);
        if (pick < 12)
            high = '0;
        else if (pick < 24)
            high = AllOnes;
        else if (pick < 50 && modulus != '0)
            high = random_word() % modulus;   // keeps the quotient within 64 bits
        else
            high = random_word() >> $urandom_range(DataWidth - 1);
        send_request(high, low, modulus);
    endtask

    task automatic test_directed();
        send_request('0, '0, DataWidth'(1));
        send_request('0, '0, AllOnes);
        send_request('0, '0, '0);
        send_request(AllOnes, AllOnes, '0);
        send_request(AllOnes, AllOnes, AllOnes);
        send_request(AllOnes, AllOnes, DataWidth'(1));
        send_request(AllOnes, AllOnes, DataWidth'(2));
        send_request(AllOnes, AllOnes, TopBit);
        send_request(AllOnes - 1, AllOnes, AllOnes);
        send_request(DataWidth'(1), '0, AllOnes);
        send_request(DataWidth'(1), '0, DataWidth'(3));
        // A zero high word must still have its low word reduced.
        send_request('0, DataWidth'(100), DataWidth'(7));
        send_request('0, AllOnes, TopBit);
        send_request('0, DataWidth'(5), DataWidth'(10));
        send_request('0, DataWidth'(64'h1234), DataWidth'(64'h1234));
        send_request('0, DataWidth'(1), AllOnes);
        send_request(AllOnes, '0, TopBit | DataWidth'(1));
        send_request(TopBit, DataWidth'(1), DataWidth'(64'hFFFF_FFFF_0000_0001));
        send_request(TopBit, '0, TopBit);
        send_request(DataWidth'(64'h5555_5555_5555_5555), DataWidth'(64'hAAAA_AAAA_AAAA_AAAA),
                     '0);
        send_request(DataWidth'(64'hAAAA_AAAA_AAAA_AAAA), DataWidth'(64'h5555_5555_5555_5555),
                     DataWidth'(64'hDEAD_BEEF_CAFE_F00D));
    endtask

    task automatic test_random_traffic(int sender_idle, int receiver_idle, int count);
        tx_idle_pct = sender_idle;
        rx_idle_pct = receiver_idle;
        repeat (count) send_random_request();
    endtask

    // The receiver stalls long enough for the block to fill and hold off the
    // sender, which keeps offering requests throughout.
    task automatic test_output_backpressure();
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold_cycles = HoldOffCycles;
        repeat (8) send_random_request();
    endtask

    task automatic test_drain_pause();
        tx_idle_pct = 0;
        rx_idle_pct = 30;
        repeat (3) send_random_request();
        wait_for_drain();
        repeat (3) send_random_request();
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.dividend_high <= '0;
        in_ch.dividend_low  <= '0;
        in_ch.modulus       <= '0;
        tx_idle_pct         = 6;
        rx_idle_pct         = 87;
        rx_hold_cycles      = 0;
        error_count         = 0;
        requests_sent       = 0;
        results_checked     = 0;
        zero_modulus_count  = 0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic(6, 87, RandomPerPhase);
        test_random_traffic(87, 6, RandomPerPhase);
        test_random_traffic(0, 0, RandomPerPhase);
        test_output_backpressure();
        test_drain_pause();

        wait_for_drain();
        repeat (SettleCycles) @(posedge clk);

        $display("Sent %0d requests (%0d with a zero modulus): corner values, three idle mixes,",
                 requests_sent, zero_modulus_count);
        $display("a long result stall and a drain pause; %0d results checked, %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/wmr_pkg.sv
hw/rtl/wmr_if.sv
hw/rtl/wmr_reduce_unit.sv
hw/rtl/wmr_sequencer.sv
hw/rtl/wide_modulo_reduce_top.sv
test/testbench.sv
